[hdl/marrg_pkg.sv]
// shared types and constants for the multi-agent rotor-router grid
// payload structs, controller/datapath command and status bundles, codes
// no dependencies
`timescale 1ns / 1ps

package marrg_pkg;

    // default sizes handed to the top level parameters
    localparam int MAX_SIDE_DEF   = 32;
    localparam int MAX_AGENTS_DEF = 8;

    // fixed field widths
    localparam int OP_W      = 2;
    localparam int COORD_W   = 5;
    localparam int ROT_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int MASK_W    = 8;
    localparam int COUNT_W   = 4;
    localparam int CFG_W     = 6;
    localparam int CFG_IDX_W = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'd1;
    localparam logic [CFG_W-1:0]     CFG_SIZE_RESET = 6'd8;

    // operation codes
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_PLACE = 2'd1;
    localparam logic [OP_W-1:0] OP_ROUND = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // directions in list order
    localparam logic [1:0] DIR_LEFT  = 2'd0;
    localparam logic [1:0] DIR_UP    = 2'd1;
    localparam logic [1:0] DIR_RIGHT = 2'd2;
    localparam logic [1:0] DIR_DOWN  = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [COORD_W-1:0] cell_col;
        logic [COORD_W-1:0] cell_row;
        logic [ROT_W-1:0]   rotor_value;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [MASK_W-1:0]   finished_mask;
        logic                all_finished;
        logic [COUNT_W-1:0]  agent_count;
    } t_out_item;

    // legal direction list of one cell
    typedef struct packed {
        logic [2:0]      len;
        logic [3:0][1:0] dir;
    } t_dirs;

    // controller to datapath
    typedef struct packed {
        logic                clr_we;
        logic                take_in;
        logic                rd_pos;
        logic                ld_write;
        logic                pl_write;
        logic                mv_write;
        logic                chk_update;
        logic                cur_clear;
        logic                cur_inc;
        logic                set_status;
        logic [STATUS_W-1:0] status;
        logic                load_out;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            in_grid;
        logic            rotor_ok;
        logic            full;
        logic            more;
        logic            cur_done;
        logic            clr_last;
    } t_sts;

endpackage

[hdl/multi_agent_rotor_router_grid.sv]
// rotor-router walk of several agents on a grid: one result item per input item
// a rejected item goes straight to its result; a round visits every placed agent in turn
// and moves only those that have not yet finished
// one item in flight; the next is taken the cycle after its result enters the output register
// reset: synchronous active low, then a clearing sweep over every word of the rotor/mark
// memory (1024 words by default), with no items taken
`timescale 1ns / 1ps

module multi_agent_rotor_router_grid #(
    parameter int MAX_SIDE   = marrg_pkg::MAX_SIDE_DEF,
    parameter int MAX_AGENTS = marrg_pkg::MAX_AGENTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration writes: grid_cols at index 0, grid_rows at index 1
    input  logic                            i_cfg_we,
    input  logic [marrg_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [marrg_pkg::CFG_W-1:0]     i_cfg_data,
    // input items
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  marrg_pkg::t_in_item             i_in_data,
    // result items
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output marrg_pkg::t_out_item            o_out_data
);

    // the controller steps through each operation; the datapath holds all storage
    //   load : decode, read cell word, write rotor back keeping its mark
    //   place: decode, read cell rotor to get the start arrow, fill agent tables
    //   round: per agent select, move (rotor read-modify-write, new position),
    //          read landing cell, check against start table and set mark
    // the rotor/mark memory has one read and one write port, read data registered,
    // so each agent move passes the select, move, next and check states and a finished agent only select
    marrg_pkg::t_cmd w_cmd;
    marrg_pkg::t_sts w_sts;

    marrg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // result register sits in the datapath and is reloaded only when the
    // previous result item has left
    marrg_dp #(
        .MAX_SIDE   (MAX_SIDE),
        .MAX_AGENTS (MAX_AGENTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_data  (o_out_data)
    );

endmodule

[hdl/marrg_ctrl.sv]
// sequencer for the rotor-router grid: clear sweep, operation decode, agent loop
// depends on marrg_pkg
`timescale 1ns / 1ps

module marrg_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  marrg_pkg::t_sts  i_sts,
    output marrg_pkg::t_cmd  o_cmd
);

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_DECODE   = 4'd2;
    localparam logic [3:0] S_LD_RD    = 4'd3;
    localparam logic [3:0] S_LD_WR    = 4'd4;
    localparam logic [3:0] S_PL_RD    = 4'd5;
    localparam logic [3:0] S_PL_WR    = 4'd6;
    localparam logic [3:0] S_RD_SEL   = 4'd7;
    localparam logic [3:0] S_RD_MOVE  = 4'd8;
    localparam logic [3:0] S_RD_NEXT  = 4'd9;
    localparam logic [3:0] S_RD_CHK   = 4'd10;
    localparam logic [3:0] S_DONE     = 4'd11;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_we = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take_in = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.set_status = 1'b1;
                o_cmd.status     = marrg_pkg::ST_OK;
                n_state          = S_DONE;
                case (i_sts.op)
                    marrg_pkg::OP_LOAD: begin
                        if (!i_sts.in_grid || !i_sts.rotor_ok) begin
                            o_cmd.status = marrg_pkg::ST_RANGE;
                        end else begin
                            n_state = S_LD_RD;
                        end
                    end
                    marrg_pkg::OP_PLACE: begin
                        if (!i_sts.in_grid) begin
                            o_cmd.status = marrg_pkg::ST_RANGE;
                        end else if (i_sts.full) begin
                            o_cmd.status = marrg_pkg::ST_FULL;
                        end else begin
                            n_state = S_PL_RD;
                        end
                    end
                    marrg_pkg::OP_ROUND: begin
                        o_cmd.cur_clear = 1'b1;
                        n_state         = S_RD_SEL;
                    end
                    default: begin
                        o_cmd.status = marrg_pkg::ST_RANGE;
                    end
                endcase
            end
            S_LD_RD: begin
                n_state = S_LD_WR;
            end
            S_LD_WR: begin
                o_cmd.ld_write = 1'b1;
                n_state        = S_DONE;
            end
            S_PL_RD: begin
                n_state = S_PL_WR;
            end
            S_PL_WR: begin
                o_cmd.pl_write = 1'b1;
                n_state        = S_DONE;
            end
            S_RD_SEL: begin
                o_cmd.rd_pos = 1'b1;
                if (!i_sts.more) begin
                    n_state = S_DONE;
                end else if (i_sts.cur_done) begin
                    o_cmd.cur_inc = 1'b1;
                end else begin
                    n_state = S_RD_MOVE;
                end
            end
            S_RD_MOVE: begin
                o_cmd.mv_write = 1'b1;
                n_state        = S_RD_NEXT;
            end
            S_RD_NEXT: begin
                o_cmd.rd_pos = 1'b1;
                n_state      = S_RD_CHK;
            end
            S_RD_CHK: begin
                o_cmd.chk_update = 1'b1;
                o_cmd.cur_inc    = 1'b1;
                n_state          = S_RD_SEL;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

[hdl/marrg_dp.sv]
// datapath for the rotor-router grid: rotor/mark memory, agent tables,
// direction lists, move and finish check, result register; depends on marrg_pkg
`timescale 1ns / 1ps

module marrg_dp #(
    parameter int MAX_SIDE   = marrg_pkg::MAX_SIDE_DEF,
    parameter int MAX_AGENTS = marrg_pkg::MAX_AGENTS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [marrg_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [marrg_pkg::CFG_W-1:0]         i_cfg_data,
    input  marrg_pkg::t_in_item                 i_in_data,
    input  marrg_pkg::t_cmd                     i_cmd,
    output marrg_pkg::t_sts                     o_sts,
    output marrg_pkg::t_out_item                o_out_data
);

    localparam int CW    = (MAX_SIDE > 2) ? $clog2(MAX_SIDE) : 1;
    localparam int SW    = CW + 1;
    localparam int AW    = 2 * CW;
    localparam int DEPTH = 1 << AW;
    localparam int AI    = (MAX_AGENTS > 1) ? $clog2(MAX_AGENTS) : 1;
    localparam int NW    = $clog2(MAX_AGENTS + 1);

    // grid size, clamped to the supported range
    function automatic logic [SW-1:0] eff_size(input logic [marrg_pkg::CFG_W-1:0] v);
        logic [SW-1:0] s;
        if (v < marrg_pkg::CFG_W'(2)) begin
            s = SW'(2);
        end else if (int'(v) > MAX_SIDE) begin
            s = SW'(MAX_SIDE);
        end else begin
            s = SW'(v);
        end
        return s;
    endfunction

    // left, up, right, down with off-grid directions dropped
    function automatic marrg_pkg::t_dirs legal_dirs(
        input logic [CW-1:0] col,
        input logic [CW-1:0] row,
        input logic [SW-1:0] cols,
        input logic [SW-1:0] rows
    );
        marrg_pkg::t_dirs d;
        logic [2:0]       n;
        d = '0;
        n = '0;
        if (col != '0) begin
            d.dir[n[1:0]] = marrg_pkg::DIR_LEFT;
            n = n + 3'd1;
        end
        if (row != '0) begin
            d.dir[n[1:0]] = marrg_pkg::DIR_UP;
            n = n + 3'd1;
        end
        if ((SW'(col) + SW'(1)) < cols) begin
            d.dir[n[1:0]] = marrg_pkg::DIR_RIGHT;
            n = n + 3'd1;
        end
        if ((SW'(row) + SW'(1)) < rows) begin
            d.dir[n[1:0]] = marrg_pkg::DIR_DOWN;
            n = n + 3'd1;
        end
        d.len = n;
        return d;
    endfunction

    // stored rotor reduced modulo the list length
    function automatic logic [1:0] eff_rotor(input logic [1:0] rot, input logic [2:0] len);
        logic [1:0] r;
        case (len)
            3'd4:    r = rot;
            3'd3:    r = (rot == 2'd3) ? 2'd0 : rot;
            3'd2:    r = {1'b0, rot[0]};
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] next_rotor(input logic [1:0] rot, input logic [2:0] len);
        logic [2:0] s;
        s = {1'b0, rot} + 3'd1;
        return (s == len) ? 2'd0 : s[1:0];
    endfunction

    // configuration
    logic [marrg_pkg::CFG_W-1:0] r_cfg_cols;
    logic [marrg_pkg::CFG_W-1:0] r_cfg_rows;
    logic [SW-1:0]               w_cols;
    logic [SW-1:0]               w_rows;

    // latched item
    logic [marrg_pkg::OP_W-1:0]    r_op;
    logic [marrg_pkg::COORD_W-1:0] r_col;
    logic [marrg_pkg::COORD_W-1:0] r_row;
    logic [marrg_pkg::ROT_W-1:0]   r_rv;

    // rotor and finish mark per cell: bit 2 mark, bits 1:0 rotor
    logic [2:0]    r_mem [DEPTH];
    logic [2:0]    r_rdata;
    logic [AW-1:0] r_clr;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [2:0]    w_wdata;
    logic [AW-1:0] w_raddr;

    // agent tables
    logic [AW-1:0]         r_start_cell  [MAX_AGENTS];
    logic [1:0]            r_start_arrow [MAX_AGENTS];
    logic [AW-1:0]         r_pos         [MAX_AGENTS];
    logic [MAX_AGENTS-1:0] r_done;
    logic [NW-1:0]         r_placed;
    logic [NW-1:0]         r_cur;
    logic [AI-1:0]         w_ci;
    logic [AI-1:0]         w_pi;

    logic [marrg_pkg::STATUS_W-1:0] r_status;
    marrg_pkg::t_out_item           r_out;

    // item cell
    logic [CW-1:0]    w_in_col;
    logic [CW-1:0]    w_in_row;
    logic [AW-1:0]    w_in_cell;
    marrg_pkg::t_dirs w_in_dirs;
    logic [1:0]       w_in_arrow;
    logic             w_inside;

    // agent cell
    logic [AW-1:0]    w_pos_cell;
    logic [CW-1:0]    w_pos_col;
    logic [CW-1:0]    w_pos_row;
    marrg_pkg::t_dirs w_pos_dirs;
    logic [1:0]       w_pos_rot;
    logic [1:0]       w_nxt_rot;
    logic [1:0]       w_step_dir;
    logic [1:0]       w_pos_arrow;
    logic [CW-1:0]    w_new_col;
    logic [CW-1:0]    w_new_row;
    logic             w_hit;
    logic             w_all;

    assign w_cols = eff_size(r_cfg_cols);
    assign w_rows = eff_size(r_cfg_rows);

    assign w_ci = r_cur[AI-1:0];
    assign w_pi = r_placed[AI-1:0];

    assign w_in_col   = CW'(r_col);
    assign w_in_row   = CW'(r_row);
    assign w_in_cell  = {w_in_row, w_in_col};
    assign w_inside   = (r_col < w_cols) && (r_row < w_rows);
    assign w_in_dirs  = legal_dirs(w_in_col, w_in_row, w_cols, w_rows);
    assign w_in_arrow = w_in_dirs.dir[eff_rotor(r_rdata[1:0], w_in_dirs.len)];

    assign w_pos_cell  = r_pos[w_ci];
    assign w_pos_col   = w_pos_cell[CW-1:0];
    assign w_pos_row   = w_pos_cell[AW-1:CW];
    assign w_pos_dirs  = legal_dirs(w_pos_col, w_pos_row, w_cols, w_rows);
    assign w_pos_rot   = eff_rotor(r_rdata[1:0], w_pos_dirs.len);
    assign w_nxt_rot   = next_rotor(w_pos_rot, w_pos_dirs.len);
    assign w_step_dir  = w_pos_dirs.dir[w_nxt_rot];
    assign w_pos_arrow = w_pos_dirs.dir[w_pos_rot];

    // one step along the new arrow
    always_comb begin
        w_new_col = w_pos_col;
        w_new_row = w_pos_row;
        case (w_step_dir)
            marrg_pkg::DIR_LEFT:  w_new_col = w_pos_col - CW'(1);
            marrg_pkg::DIR_UP:    w_new_row = w_pos_row - CW'(1);
            marrg_pkg::DIR_RIGHT: w_new_col = w_pos_col + CW'(1);
            default:              w_new_row = w_pos_row + CW'(1);
        endcase
    end

    // landed on some start cell showing its start arrow, mark still clear
    always_comb begin
        w_hit = 1'b0;
        for (int j = 0; j < MAX_AGENTS; j++) begin
            if ((NW'(j) < r_placed) && (r_start_cell[j] == w_pos_cell)
                    && (r_start_arrow[j] == w_pos_arrow)) begin
                w_hit = 1'b1;
            end
        end
        w_hit = w_hit && !r_rdata[2];
    end

    // all placed agents finished, true with none placed
    always_comb begin
        w_all = 1'b1;
        for (int k = 0; k < MAX_AGENTS; k++) begin
            if ((NW'(k) < r_placed) && !r_done[k]) begin
                w_all = 1'b0;
            end
        end
    end

    // memory port selection
    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_pos_cell;
        w_wdata = {r_rdata[2], w_nxt_rot};
        if (i_cmd.clr_we) begin
            w_we    = 1'b1;
            w_waddr = r_clr;
            w_wdata = '0;
        end else if (i_cmd.ld_write) begin
            w_we    = 1'b1;
            w_waddr = w_in_cell;
            w_wdata = {r_rdata[2], r_rv};
        end else if (i_cmd.mv_write) begin
            w_we    = 1'b1;
        end else if (i_cmd.chk_update && w_hit) begin
            w_we    = 1'b1;
            w_wdata = {1'b1, r_rdata[1:0]};
        end
    end

    assign w_raddr = i_cmd.rd_pos ? w_pos_cell : w_in_cell;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_cols <= marrg_pkg::CFG_SIZE_RESET;
            r_cfg_rows <= marrg_pkg::CFG_SIZE_RESET;
            r_clr      <= '0;
            r_done     <= '0;
            r_placed   <= '0;
            r_cur      <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    marrg_pkg::CFG_COLS: r_cfg_cols <= i_cfg_data;
                    marrg_pkg::CFG_ROWS: r_cfg_rows <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.clr_we) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cmd.pl_write) begin
                r_done[w_pi] <= 1'b0;
                r_placed     <= r_placed + NW'(1);
            end
            if (i_cmd.chk_update && w_hit) begin
                r_done[w_ci] <= 1'b1;
            end
            if (i_cmd.cur_clear) begin
                r_cur <= '0;
            end else if (i_cmd.cur_inc) begin
                r_cur <= r_cur + NW'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_op  <= i_in_data.operation;
            r_col <= i_in_data.cell_col;
            r_row <= i_in_data.cell_row;
            r_rv  <= i_in_data.rotor_value;
        end
        if (i_cmd.pl_write) begin
            r_start_cell[w_pi]  <= w_in_cell;
            r_start_arrow[w_pi] <= w_in_arrow;
            r_pos[w_pi]         <= w_in_cell;
        end
        if (i_cmd.mv_write) begin
            r_pos[w_ci] <= {w_new_row, w_new_col};
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
        end
        if (i_cmd.load_out) begin
            r_out.status        <= r_status;
            r_out.finished_mask <= marrg_pkg::MASK_W'(r_done);
            r_out.all_finished  <= w_all;
            r_out.agent_count   <= marrg_pkg::COUNT_W'(r_placed);
        end
    end

    assign o_sts.op       = r_op;
    assign o_sts.in_grid  = w_inside;
    assign o_sts.rotor_ok = ({1'b0, r_rv} < w_in_dirs.len);
    assign o_sts.full     = (int'(r_placed) >= MAX_AGENTS);
    assign o_sts.more     = (r_cur < r_placed);
    assign o_sts.cur_done = r_done[w_ci];
    assign o_sts.clr_last = (r_clr == '1);

    assign o_out_data = r_out;

endmodule
